// ----- rtl/shipdb_pkg.sv -----
// Shared types and constants of the dead-block RRIP replacement block.
package shipdb_pkg;

  // Fixed widths of the item fields
  localparam int unsigned SET_W    = 11;
  localparam int unsigned WAY_W    = 4;
  localparam int unsigned PC_W     = 12;
  localparam int unsigned VICTIM_W = 4;

  // Action codes
  localparam logic ACT_VICTIM = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // Counter limits and insertion values
  localparam logic [1:0] RRPV_MAX   = 2'd3;
  localparam logic [1:0] RRPV_LONG  = 2'd2;
  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [1:0] DEAD_MAX   = 2'd3;
  localparam logic [1:0] OC_MAX     = 2'd3;
  localparam logic [1:0] OC_STRONG  = 2'd2;

  // One cache line's replacement state
  typedef struct packed {
    logic [1:0] dead;
    logic [1:0] rrpv;
  } line_t;

  localparam int unsigned LINE_W = $bits(line_t);
  localparam line_t LINE_RESET = '{dead: 2'd0, rrpv: 2'd3};

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

// ----- rtl/shipdb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module shipdb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and read the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/shipdb_ctrl.sv -----
// Controller: clearing pass, item intake and write-back sequencing.
module shipdb_ctrl import shipdb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Sequence the states
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/shipdb_dp.sv -----
// Datapath: set rows, outcome table, victim search, line update and selector.
module shipdb_dp import shipdb_pkg::*; #(
  parameter int unsigned SETS          = 2048,
  parameter int unsigned WAYS          = 16,
  parameter int unsigned LEADER_SETS   = 64,
  parameter int unsigned SIG_BITS      = 6,
  parameter int unsigned SELECTOR_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     action_i,
  input  logic [SET_W-1:0]         set_index_i,
  input  logic [WAY_W-1:0]         way_i,
  input  logic [PC_W-1:0]          pc_low_i,
  input  logic                     hit_i,
  output logic [VICTIM_W-1:0]      victim_way_o,
  output logic [SELECTOR_BITS-1:0] selector_value_o
);

  localparam int unsigned SW        = $clog2(SETS);
  localparam int unsigned WW        = $clog2(WAYS);
  localparam int unsigned SIG_COUNT = 1 << SIG_BITS;
  localparam int unsigned CLR_LEN   = (SETS > SIG_COUNT) ? SETS : SIG_COUNT;
  localparam int unsigned CW        = $clog2(CLR_LEN);
  localparam int unsigned ROW_W     = WAYS * LINE_W;
  localparam int unsigned SET_QB    = $clog2(((1 << SET_W) - 1) / SETS + 1);
  localparam int unsigned WAY_QB    = $clog2(((1 << WAY_W) - 1) / WAYS + 1);
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_MAX >> 1;

  // Captured item
  logic                action_q;
  logic [SW-1:0]       set_q;
  logic [WW-1:0]       way_q;
  logic                hit_q;
  logic [SIG_BITS-1:0] sig_q;

  logic [SET_W-1:0]    set_rem;
  logic [WAY_W-1:0]    way_rem;
  logic [SW-1:0]       set_red;
  logic [WW-1:0]       way_red;
  logic [SIG_BITS-1:0] sig_in;

  logic [CW-1:0]       cnt_q;
  logic [SELECTOR_BITS-1:0] sel_q, sel_d;
  logic [VICTIM_W-1:0] victim_q;

  logic                row_we;
  logic [SW-1:0]       row_waddr, row_raddr, clr_row_addr;
  logic [ROW_W-1:0]    row_wdata, row_rdata;
  logic                oc_we;
  logic [SIG_BITS-1:0] oc_waddr, oc_raddr;
  logic [1:0]          oc_wdata, oc_rdata;

  line_t [WAYS-1:0]    row_rd, aged1, aged2, victim_row, upd_row;
  logic                found_dead, found_max;
  logic [WW-1:0]       idx_dead, idx_max, victim_idx;

  line_t               cur_line;
  logic [1:0]          new_dead, oc_new, ins;
  logic                leader, srrip_leader, srrip_mode, sel_up;

  // Reduce set and way into range by compare and subtract
  always_comb begin
    set_rem = set_index_i;
    for (int i = int'(SET_QB) - 1; i >= 0; i--) begin
      if (32'(set_rem) >= (SETS << i)) begin
        set_rem = set_rem - SET_W'(SETS << i);
      end
    end
    way_rem = way_i;
    for (int i = int'(WAY_QB) - 1; i >= 0; i--) begin
      if (32'(way_rem) >= (WAYS << i)) begin
        way_rem = way_rem - WAY_W'(WAYS << i);
      end
    end
  end

  assign set_red = SW'(set_rem);
  assign way_red = WW'(way_rem);
  assign sig_in  = SIG_BITS'(pc_low_i ^ (pc_low_i >> SIG_BITS));

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_i;
      set_q    <= set_red;
      way_q    <= way_red;
      hit_q    <= hit_i;
      sig_q    <= sig_in;
    end
  end

  // Read at the incoming item, hold the address while it is worked on
  assign row_raddr = cmd_i.accept ? set_red : set_q;
  assign oc_raddr  = cmd_i.accept ? sig_in  : sig_q;

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (cnt_q == CW'(CLR_LEN - 1));
  assign clr_row_addr     = (32'(cnt_q) < SETS) ? SW'(cnt_q) : '0;

  assign row_rd = row_rdata;

  // Victim search: dead and distant first, else age once; if still no line is distant, age again and take way 0
  always_comb begin
    found_dead = 1'b0;
    idx_dead   = '0;
    found_max  = 1'b0;
    idx_max    = '0;
    for (int w = int'(WAYS) - 1; w >= 0; w--) begin
      aged1[w] = row_rd[w];
      if (row_rd[w].rrpv != RRPV_MAX) begin
        aged1[w].rrpv = row_rd[w].rrpv + 2'd1;
      end
      aged2[w] = aged1[w];
      if (aged1[w].rrpv != RRPV_MAX) begin
        aged2[w].rrpv = aged1[w].rrpv + 2'd1;
      end
      if (row_rd[w].rrpv == RRPV_MAX && row_rd[w].dead == DEAD_MAX) begin
        found_dead = 1'b1;
        idx_dead   = WW'(w);
      end
      if (aged1[w].rrpv == RRPV_MAX) begin
        found_max = 1'b1;
        idx_max   = WW'(w);
      end
    end
    if (found_dead) begin
      victim_row = row_rd;
      victim_idx = idx_dead;
    end else if (found_max) begin
      victim_row = aged1;
      victim_idx = idx_max;
    end else begin
      victim_row = aged2;
      victim_idx = '0;
    end
  end

  // Line update after a hit or fill
  assign leader       = 32'(set_q) < LEADER_SETS;
  assign srrip_leader = 32'(set_q) < (LEADER_SETS / 2);
  assign srrip_mode   = leader ? srrip_leader : (sel_q >= SEL_MID);
  assign cur_line     = row_rd[way_q];
  assign sel_up       = srrip_leader ? hit_q : !hit_q;

  always_comb begin
    if (hit_q) begin
      new_dead = 2'd0;
      oc_new   = (oc_rdata == OC_MAX) ? OC_MAX : oc_rdata + 2'd1;
    end else begin
      new_dead = (cur_line.dead == DEAD_MAX) ? DEAD_MAX : cur_line.dead + 2'd1;
      oc_new   = (oc_rdata == 2'd0) ? 2'd0 : oc_rdata - 2'd1;
    end
    if (hit_q || oc_new >= OC_STRONG) begin
      ins = RRPV_NEAR;
    end else begin
      ins = srrip_mode ? RRPV_LONG : RRPV_MAX;
    end
    if (!hit_q && new_dead == DEAD_MAX) begin
      ins = RRPV_MAX;
    end
    upd_row        = row_rd;
    upd_row[way_q] = '{dead: new_dead, rrpv: ins};
  end

  // Step the duel selector on leader sets
  always_comb begin
    sel_d = sel_q;
    if (cmd_i.commit && action_q == ACT_UPDATE && leader) begin
      if (sel_up) begin
        if (sel_q != SEL_MAX) begin
          sel_d = sel_q + 1'b1;
        end
      end else if (sel_q != '0) begin
        sel_d = sel_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SEL_MID;
    end else begin
      sel_q <= sel_d;
    end
  end

  // Load the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      victim_q <= (action_q == ACT_UPDATE) ? '0 : VICTIM_W'(victim_idx);
    end
  end

  // Write back, or clear during the pass after reset
  assign row_we    = cmd_i.clear || cmd_i.commit;
  assign row_waddr = cmd_i.clear ? clr_row_addr : set_q;
  assign row_wdata = cmd_i.clear ? {WAYS{LINE_RESET}} :
                     (action_q == ACT_UPDATE) ? upd_row : victim_row;

  assign oc_we    = cmd_i.clear || (cmd_i.commit && action_q == ACT_UPDATE);
  assign oc_waddr = cmd_i.clear ? cnt_q[SIG_BITS-1:0] : sig_q;
  assign oc_wdata = cmd_i.clear ? 2'd0 : oc_new;

  shipdb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  shipdb_ram #(
    .WIDTH (2),
    .DEPTH (SIG_COUNT)
  ) u_oc_ram (
    .clk_i   (clk_i),
    .we_i    (oc_we),
    .waddr_i (oc_waddr),
    .wdata_i (oc_wdata),
    .raddr_i (oc_raddr),
    .rdata_o (oc_rdata)
  );

  assign victim_way_o     = victim_q;
  assign selector_value_o = sel_q;

endmodule

// ----- rtl/ship_dead_block_rrip_replacement.sv -----
// Top level of the dead-block RRIP cache replacement policy.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o    action_i set_index_i way_i pc_low_i hit_i
//   out      output     out_valid_o / out_ready_i  victim_way_o selector_value_o
//
// For each item the set row and the outcome counter are first read from their
// RAMs, then modified and written back while the result is loaded.
// After reset a clearing pass initializes both RAMs; no item is taken meanwhile.
// A result that is not taken stalls the write-back of the following item.
module ship_dead_block_rrip_replacement import shipdb_pkg::*; #(
  parameter int unsigned SETS          = 2048,
  parameter int unsigned WAYS          = 16,
  parameter int unsigned LEADER_SETS   = 64,
  parameter int unsigned SIG_BITS      = 6,
  parameter int unsigned SELECTOR_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [SET_W-1:0]         set_index_i,
  input  logic [WAY_W-1:0]         way_i,
  input  logic [PC_W-1:0]          pc_low_i,
  input  logic                     hit_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [VICTIM_W-1:0]      victim_way_o,
  output logic [SELECTOR_BITS-1:0] selector_value_o
);

  cmd_t cmd;
  sts_t sts;

  shipdb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  shipdb_dp #(
    .SETS          (SETS),
    .WAYS          (WAYS),
    .LEADER_SETS   (LEADER_SETS),
    .SIG_BITS      (SIG_BITS),
    .SELECTOR_BITS (SELECTOR_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .set_index_i      (set_index_i),
    .way_i            (way_i),
    .pc_low_i         (pc_low_i),
    .hit_i            (hit_i),
    .victim_way_o     (victim_way_o),
    .selector_value_o (selector_value_o)
  );

endmodule

// ----- sim/ship_rrip_checker.sv -----
// Checker for the dead-block RRIP replacement block: predicts every result and compares it.
`timescale 1ns / 100ps

module ship_rrip_checker import shipdb_pkg::*; #(
  parameter int unsigned SETS          = 2048,
  parameter int unsigned WAYS          = 16,
  parameter int unsigned LEADER_SETS   = 64,
  parameter int unsigned SIG_BITS      = 6,
  parameter int unsigned SELECTOR_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     action_i,
  input  logic [SET_W-1:0]         set_index_i,
  input  logic [WAY_W-1:0]         way_i,
  input  logic [PC_W-1:0]          pc_low_i,
  input  logic                     hit_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [VICTIM_W-1:0]      victim_way_i,
  input  logic [SELECTOR_BITS-1:0] selector_value_i,
  output int unsigned              pending_o,
  output int unsigned              fail_count_o
);

  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
  localparam int unsigned SIG_COUNT = 1 << SIG_BITS;

  typedef struct packed {
    logic [VICTIM_W-1:0]      victim;
    logic [SELECTOR_BITS-1:0] selector;
  } replacement_t;

  // Shadow copy of the replacement state
  logic [1:0]               rrpv_q     [SETS][WAYS];
  logic [1:0]               dead_q     [SETS][WAYS];
  logic [1:0]               outcome_q  [SIG_COUNT];
  logic [SELECTOR_BITS-1:0] selector_q;

  replacement_t expected_q [$];
  int unsigned  mismatches;

  // Age every line of a set that is not yet at the distant value
  function automatic void age_row(int unsigned s);
    for (int w = 0; w < WAYS; w++) begin
      if (rrpv_q[s][w] != RRPV_MAX) rrpv_q[s][w] = rrpv_q[s][w] + 2'd1;
    end
  endfunction

  // Prefer a dead distant line, else age once; if no line is distant yet, age again and take way 0
  function automatic logic [VICTIM_W-1:0] find_victim(int unsigned s);
    for (int w = 0; w < WAYS; w++) begin
      if (rrpv_q[s][w] == RRPV_MAX && dead_q[s][w] == DEAD_MAX) return VICTIM_W'(w);
    end
    age_row(s);
    for (int w = 0; w < WAYS; w++) begin
      if (rrpv_q[s][w] == RRPV_MAX) return VICTIM_W'(w);
    end
    age_row(s);
    return '0;
  endfunction

  // Train the counters, insert the line, then step the selector
  function automatic void train_line(int unsigned s, int unsigned w,
                                     logic [PC_W-1:0] pc, logic h);
    int unsigned sig;
    logic        leader;
    logic        srrip_leader;
    logic        srrip_mode;
    logic [1:0]  ins;
    sig          = ((pc ^ (pc >> SIG_BITS)) & (SIG_COUNT - 1));
    leader       = (s < LEADER_SETS);
    srrip_leader = (s < LEADER_SETS / 2);

    if (h) dead_q[s][w] = 2'd0;
    else if (dead_q[s][w] != DEAD_MAX) dead_q[s][w] = dead_q[s][w] + 2'd1;

    if (h) begin
      if (outcome_q[sig] != OC_MAX) outcome_q[sig] = outcome_q[sig] + 2'd1;
    end else if (outcome_q[sig] != 2'd0) begin
      outcome_q[sig] = outcome_q[sig] - 2'd1;
    end

    srrip_mode = leader ? srrip_leader : (selector_q >= SEL_MAX / 2);
    if (h || outcome_q[sig] >= OC_STRONG) ins = RRPV_NEAR;
    else ins = srrip_mode ? RRPV_LONG : RRPV_MAX;
    if (!h && dead_q[s][w] == DEAD_MAX) ins = RRPV_MAX;
    rrpv_q[s][w] = ins;

    // Leader sets steer the duel selector, saturating at both ends
    if (leader) begin
      if (srrip_leader ? h : !h) begin
        if (selector_q != SEL_MAX) selector_q = selector_q + 1'b1;
      end else if (selector_q != '0) begin
        selector_q = selector_q - 1'b1;
      end
    end
  endfunction

  function automatic replacement_t predict_replacement(logic act, logic [SET_W-1:0] s,
                                                       logic [WAY_W-1:0] w,
                                                       logic [PC_W-1:0] pc, logic h);
    replacement_t r;
    r.victim = '0;
    if (act == ACT_VICTIM) r.victim = find_victim(s % SETS);
    else train_line(s % SETS, w % WAYS, pc, h);
    r.selector = selector_q;
    return r;
  endfunction

  // Retire results before taking new items seen at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    replacement_t oldest;
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          rrpv_q[s][w] = RRPV_MAX;
          dead_q[s][w] = 2'd0;
        end
      end
      for (int i = 0; i < SIG_COUNT; i++) outcome_q[i] = 2'd0;
      selector_q = SEL_MAX / 2;
      expected_q.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t result with nothing expected: victim_way %0d selector_value %0d",
                   $time, victim_way_i, selector_value_i);
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          if (victim_way_i !== oldest.victim) begin
            $display("%0t victim_way mismatch: expected %0d actual %0d",
                     $time, oldest.victim, victim_way_i);
            mismatches++;
          end
          if (selector_value_i !== oldest.selector) begin
            $display("%0t selector_value mismatch: expected %0d actual %0d",
                     $time, oldest.selector, selector_value_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict_replacement(action_i, set_index_i, way_i,
                                                 pc_low_i, hit_i));
      end
      pending_o    <= expected_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- sim/tb_ship_dead_block_rrip_replacement.sv -----
// Testbench top for the dead-block RRIP replacement block: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_ship_dead_block_rrip_replacement;
  import shipdb_pkg::*;

  localparam int unsigned SELECTOR_BITS = 10;
  localparam int unsigned LIMIT_CYCLES  = 800_000;

  typedef enum logic [1:0] {
    MIX_GENERAL,
    PUSH_UP,
    PUSH_DOWN
  } mix_e;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     action = ACT_VICTIM;
  logic [SET_W-1:0]         set_index = '0;
  logic [WAY_W-1:0]         way = '0;
  logic [PC_W-1:0]          pc_low = '0;
  logic                     hit = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [VICTIM_W-1:0]      victim_way;
  logic [SELECTOR_BITS-1:0] selector_value;

  int unsigned pending;
  int unsigned fail_count;
  logic        calm = 1'b1;
  int unsigned stall_left = 0;

  logic [SET_W-1:0] set_pool [6];
  logic [PC_W-1:0]  pc_pool  [8];

  ship_dead_block_rrip_replacement DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .set_index_i     (set_index),
    .way_i           (way),
    .pc_low_i        (pc_low),
    .hit_i           (hit),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .victim_way_o    (victim_way),
    .selector_value_o(selector_value)
  );

  ship_rrip_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .action_i        (action),
    .set_index_i     (set_index),
    .way_i           (way),
    .pc_low_i        (pc_low),
    .hit_i           (hit),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .victim_way_i    (victim_way),
    .selector_value_i(selector_value),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the result channel at random, mostly briefly
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      out_ready <= 1'b0;
      if ($urandom_range(0, 19) == 0) stall_left <= $urandom_range(15, 50);
      else stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one item and hold it until it is taken
  task automatic send_item(input int unsigned gap, input logic act,
                           input logic [SET_W-1:0] s, input logic [WAY_W-1:0] w,
                           input logic [PC_W-1:0] pc, input logic h);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    action    <= act;
    set_index <= s;
    way       <= w;
    pc_low    <= pc;
    hit       <= h;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Hold off new items until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Build one random item; leader-heavy mixes drive the selector toward an end
  task automatic random_item(input mix_e mix);
    logic             act;
    logic [SET_W-1:0] s;
    logic [WAY_W-1:0] w;
    logic [PC_W-1:0]  pc;
    logic             h;
    logic             up;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    w    = WAY_W'($urandom_range(0, 15));
    pc   = ($urandom_range(0, 99) < 60) ? pc_pool[$urandom_range(0, 7)] : PC_W'($urandom);
    h    = 1'($urandom_range(0, 1));
    if (mix != MIX_GENERAL && roll < 85) begin
      act = ACT_UPDATE;
      up  = (mix == PUSH_UP) ^ ($urandom_range(0, 99) < 5);
      if ($urandom_range(0, 1) == 1) begin
        s = SET_W'($urandom_range(0, 31));
        h = up;
      end else begin
        s = SET_W'($urandom_range(32, 63));
        h = !up;
      end
    end else begin
      act  = ($urandom_range(0, 99) < 35) ? ACT_VICTIM : ACT_UPDATE;
      roll = $urandom_range(0, 99);
      if (roll < 50) s = set_pool[$urandom_range(0, 5)];
      else if (roll < 70) s = SET_W'($urandom_range(0, 63));
      else s = SET_W'($urandom);
      if ($urandom_range(0, 99) < 60) w = WAY_W'($urandom_range(0, 3));
    end
    send_item(idle_gap(), act, s, w, pc, h);
  endtask

  task automatic run_mix(input mix_e mix, input int unsigned count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 4) == 0);
      random_item(mix);
    end
  endtask

  initial begin : stimulus
    set_pool[0] = 11'd0;
    set_pool[1] = 11'd63;
    set_pool[2] = 11'd2047;
    for (int i = 3; i < 6; i++) set_pool[i] = SET_W'($urandom);
    for (int i = 0; i < 8; i++) pc_pool[i] = PC_W'($urandom);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fresh set: everything distant, way 0 wins at once
    send_item(0, ACT_VICTIM, 11'd0, 4'd0, 12'd0, 1'b0);
    // Fill a follower set with hits so a victim search ages twice
    for (int w = 0; w < 16; w++) send_item(0, ACT_UPDATE, 11'd100, WAY_W'(w), 12'h123, 1'b1);
    send_item(0, ACT_VICTIM, 11'd100, 4'd15, 12'hFFF, 1'b1);
    // Three misses make a line dead, then the dead line is chosen first
    for (int i = 0; i < 3; i++) send_item(0, ACT_UPDATE, 11'd2047, 4'd15, 12'hFFF, 1'b0);
    send_item(0, ACT_VICTIM, 11'd2047, 4'd0, 12'd0, 1'b0);
    // Miss with a strong outcome counter, then leader hits and misses both ways
    send_item(0, ACT_UPDATE, 11'd63, 4'd0, 12'h123, 1'b0);
    send_item(0, ACT_UPDATE, 11'd32, 4'd3, 12'd0, 1'b1);
    send_item(0, ACT_UPDATE, 11'd31, 4'd1, 12'h040, 1'b0);
    drain();

    calm = 1'b0;
    run_mix(PUSH_UP, 600);
    drain();
    run_mix(PUSH_DOWN, 700);
    drain();
    run_mix(MIX_GENERAL, 550);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/shipdb_pkg.sv
rtl/shipdb_ram.sv
rtl/shipdb_ctrl.sv
rtl/shipdb_dp.sv
rtl/ship_dead_block_rrip_replacement.sv
sim/ship_rrip_checker.sv
sim/tb_ship_dead_block_rrip_replacement.sv
